### rtl/keyed_record_table_defines.svh
// Assertion macros used by the file that checks this block.
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define KRT_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("keyed_record_table check failed");

// A consequence that holds in the same cycle as its cause.
`define KRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_record_table check failed");

// A consequence that holds in the cycle after its cause.
`define KRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_record_table check failed");

`endif

### rtl/krt_pkg.sv
package krt_pkg;

  localparam int ENTRIES_DEFAULT   = 128;
  localparam int KEY_WIDTH_DEFAULT = 16;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

endpackage

### rtl/krt_ram.sv
module krt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/keyed_record_table.sv
// Keyed record table: key/value pairs held in insertion order.
// Commands arrive on the s_ stream, one word each, and every command gives
// exactly one result word on the m_ stream. Append stores a pair at the end,
// search/update/delete walk the table from entry 0 for the first key match,
// and read returns the entry at a given index.
// Sequence after a command is accepted: append, unknown commands and any
// lookup in an empty table go straight to S_DONE, read passes through
// S_RD_WAIT and S_RD_DATA, search and update walk up to the hit or to the
// end of the table, and delete walks the whole table whether it hits or not,
// because the walk and the shift together visit every entry once. The key
// and value memories have a single read port, which the sequencer steps
// through one entry per cycle for both the walk and the shift.
// One command is worked on at a time; s_tready is high only while idle, so
// the next command is taken at the earliest in the cycle the result is first presented.
// A finished result sits in the output register, so a stalled receiver
// holds the block only once the next result is ready to go out.
// Reset empties the table at once (the count goes to zero); no clearing pass
// is needed and the stored entries are never read before they are written.
`include "keyed_record_table_defines.svh"

module keyed_record_table #(
  parameter int ENTRIES   = krt_pkg::ENTRIES_DEFAULT,
  parameter int KEY_WIDTH = krt_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], key[18:3], value[34:19], position[41:35], zero fill above
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], hit_key[17:2], hit_value[33:18], hit_index[40:34],
  // entry_count[48:41], zero fill above
  output logic [55:0] m_tdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RD_WAIT,
    S_RD_DATA,
    S_DONE
  } state_t;

  state_t state;

  // Input word fields.
  krt_pkg::cmd_t  in_cmd;
  logic [15:0]    in_key;
  logic [15:0]    in_value;
  logic [6:0]     in_pos;
  logic [31:0]    in_key_wide;
  logic [KEY_WIDTH-1:0] in_key_m;
  logic [31:0]    in_key_m_wide;
  logic [31:0]    in_pos_wide;

  // Held command.
  krt_pkg::cmd_t  cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [31:0]    key_r_wide;
  logic [15:0]    value_r;
  logic [6:0]     pos_r;

  // Walk and shift control.
  logic [CW-1:0]  count;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  cidx;
  logic [AW-1:0]  wptr;
  logic           pend;
  logic [31:0]    cidx_wide;
  logic [31:0]    count_wide;
  logic           full;
  logic           cidx_last;
  logic           match;
  logic           accept;
  logic           append_ok;

  // Memory ports.
  logic                 we_key;
  logic                 we_val;
  logic [AW-1:0]        waddr;
  logic [KEY_WIDTH-1:0] wkey;
  logic [15:0]          wval;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [15:0]          rd_value;
  logic [31:0]          rd_key_wide;

  // Result being built.
  krt_pkg::status_t res_status;
  logic [15:0]    res_key;
  logic [15:0]    res_value;
  logic [6:0]     res_index;

  assign in_cmd        = krt_pkg::cmd_t'(s_tdata[2:0]);
  assign in_key        = s_tdata[18:3];
  assign in_value      = s_tdata[34:19];
  assign in_pos        = s_tdata[41:35];
  assign in_key_wide   = 32'(in_key);
  assign in_key_m      = in_key_wide[KEY_WIDTH-1:0];
  assign in_key_m_wide = 32'(in_key_m);
  assign in_pos_wide   = 32'(in_pos);
  assign key_r_wide    = 32'(key_r);
  assign rd_key_wide   = 32'(rd_key);
  assign cidx_wide     = 32'(cidx);
  assign count_wide    = 32'(count);

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign full      = (count == CW'(ENTRIES));
  assign append_ok = accept && (in_cmd == krt_pkg::CMD_APPEND) && !full;
  assign cidx_last = ((CW'(cidx) + ONE_C) == count);
  assign match     = (state == S_SCAN) && pend && (rd_key == key_r);

  // Only one of append, update or shift writes in any cycle.
  always_comb begin
    we_key = 1'b0;
    we_val = 1'b0;
    waddr  = count[AW-1:0];
    wkey   = in_key_m;
    wval   = in_value;
    if (append_ok) begin
      we_key = 1'b1;
      we_val = 1'b1;
    end else if (match && (cmd_r == krt_pkg::CMD_UPDATE)) begin
      we_val = 1'b1;
      waddr  = cidx;
      wval   = value_r;
    end else if (state == S_SHIFT) begin
      we_key = 1'b1;
      we_val = 1'b1;
      waddr  = wptr;
      wkey   = rd_key;
      wval   = rd_value;
    end
  end

  krt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (we_key),
    .waddr (waddr),
    .wdata (wkey),
    .raddr (raddr),
    .rdata (rd_key)
  );

  krt_ram #(
    .WIDTH (16),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (we_val),
    .waddr (waddr),
    .wdata (wval),
    .raddr (raddr),
    .rdata (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r      <= in_cmd;
            key_r      <= in_key_m;
            value_r    <= in_value;
            pos_r      <= in_pos;
            raddr      <= '0;
            pend       <= 1'b0;
            res_status <= krt_pkg::ST_OK;
            res_key    <= '0;
            res_value  <= '0;
            res_index  <= '0;
            case (in_cmd)
              krt_pkg::CMD_APPEND: begin
                res_key <= in_key_m_wide[15:0];
                if (full) begin
                  res_status <= krt_pkg::ST_FULL;
                end else begin
                  count     <= count + ONE_C;
                  res_index <= count_wide[6:0];
                end
                state <= S_DONE;
              end
              krt_pkg::CMD_SEARCH, krt_pkg::CMD_UPDATE, krt_pkg::CMD_DELETE: begin
                if (count == '0) begin
                  res_status <= krt_pkg::ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              krt_pkg::CMD_READ: begin
                if (in_pos_wide >= count_wide) begin
                  res_status <= krt_pkg::ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  raddr <= in_pos_wide[AW-1:0];
                  state <= S_RD_WAIT;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // The read address runs one entry ahead of the compare, so on a
          // delete hit the entry after the match is already being fetched.
          pend  <= 1'b1;
          cidx  <= raddr;
          raddr <= raddr + AW'(1);
          if (pend) begin
            if (match) begin
              res_key   <= key_r_wide[15:0];
              res_value <= rd_value;
              res_index <= cidx_wide[6:0];
              wptr      <= cidx;
              if (cmd_r == krt_pkg::CMD_DELETE) begin
                count <= count - ONE_C;
                state <= cidx_last ? S_DONE : S_SHIFT;
              end else begin
                state <= S_DONE;
              end
            end else if (cidx_last) begin
              res_status <= krt_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end
        end
        S_SHIFT: begin
          raddr <= raddr + AW'(1);
          wptr  <= wptr + AW'(1);
          if ((CW'(wptr) + ONE_C) == count) begin
            state <= S_DONE;
          end
        end
        S_RD_WAIT: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_key   <= rd_key_wide[15:0];
          res_value <= rd_value;
          res_index <= pos_r;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, count_wide[7:0], res_index, res_value, res_key,
                         res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KRT_ASSERT(a_count_range, count <= CW'(ENTRIES))
  `KRT_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
  `KRT_ASSERT_NEXT(a_append_grows, append_ok, count == $past(count) + ONE_C)
  `KRT_ASSERT_IMPL(a_shift_in_table, state == S_SHIFT, (CW'(wptr) + ONE_C) <= count)

endmodule

### dv/tb_keyed_record_table.sv
module tb_keyed_record_table;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = krt_pkg::ENTRIES_DEFAULT;
  localparam int CMD_CODE_MAX = 7;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] key;
    logic [15:0] value;
    logic [6:0]  position;
  } cmd_word_t;

  typedef struct packed {
    krt_pkg::status_t status;
    logic [15:0] hit_key;
    logic [15:0] hit_value;
    logic [6:0]  hit_index;
    logic [7:0]  entry_count;
  } table_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  cmd_word_t     command_backlog[$];
  table_result_t predicted_results[$];

  logic [15:0] shadow_keys[TABLE_DEPTH];
  logic [15:0] shadow_values[TABLE_DEPTH];
  int          shadow_count = 0;

  int error_count = 0;
  int send_gap = 0;
  int send_quiet = 0;
  int recv_stall = 0;
  int recv_quiet = 0;

  keyed_record_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps with an occasional long one; none during a quiet stretch.
  function automatic int pick_gap(input int quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet != 0 || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int next_quiet(input int quiet);
    if (quiet != 0) return quiet - 1;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return 0;
  endfunction

  // Most keys come from two small pools so that matches and duplicates are common.
  function automatic logic [15:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 16'($urandom_range(0, 31));
    if (roll < 85) return 16'hFFE0 | 16'($urandom_range(0, 31));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [15:0] k,
                           input logic [15:0] v, input logic [6:0] pos);
    command_backlog.push_back('{op, k, v, pos});
  endtask

  // Applies one accepted command to the shadow table and records its result.
  task automatic table_apply(input logic [47:0] word);
    logic [2:0]    op;
    logic [15:0]   k;
    logic [15:0]   v;
    logic [6:0]    pos;
    table_result_t r;
    int            hit;
    int            i;
    op  = word[2:0];
    k   = word[18:3];
    v   = word[34:19];
    pos = word[41:35];
    r   = '{krt_pkg::ST_OK, 16'h0, 16'h0, 7'h0, 8'h0};
    case (op)
      krt_pkg::CMD_APPEND: begin
        if (shadow_count >= TABLE_DEPTH) begin
          r.status  = krt_pkg::ST_FULL;
          r.hit_key = k;
        end else begin
          shadow_keys[shadow_count]   = k;
          shadow_values[shadow_count] = v;
          r.hit_key   = k;
          r.hit_index = shadow_count[6:0];
          shadow_count++;
        end
      end
      krt_pkg::CMD_SEARCH, krt_pkg::CMD_UPDATE, krt_pkg::CMD_DELETE: begin
        hit = -1;
        for (i = 0; i < shadow_count && hit < 0; i++) begin
          if (shadow_keys[i] == k) hit = i;
        end
        if (hit < 0) begin
          r.status = krt_pkg::ST_NOT_FOUND;
        end else begin
          r.hit_key   = k;
          r.hit_value = shadow_values[hit];
          r.hit_index = hit[6:0];
          if (op == krt_pkg::CMD_UPDATE) begin
            shadow_values[hit] = v;
          end else if (op == krt_pkg::CMD_DELETE) begin
            for (i = hit; i + 1 < shadow_count; i++) begin
              shadow_keys[i]   = shadow_keys[i + 1];
              shadow_values[i] = shadow_values[i + 1];
            end
            shadow_count--;
          end
        end
      end
      krt_pkg::CMD_READ: begin
        if (pos >= shadow_count) begin
          r.status = krt_pkg::ST_RANGE;
        end else begin
          r.hit_key   = shadow_keys[pos];
          r.hit_value = shadow_values[pos];
          r.hit_index = pos;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_count[7:0];
    predicted_results.push_back(r);
  endtask

  task automatic field_check(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      error_count++;
    end
  endtask

  // Driver: presents the next pending word, then optionally idles for a while.
  always @(posedge clk) begin
    cmd_word_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap != 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (command_backlog.size() != 0) begin
        nxt = command_backlog.pop_front();
        s_tdata    <= {6'd0, nxt.position, nxt.value, nxt.key, nxt.command};
        s_tvalid   <= 1'b1;
        send_gap   <= pick_gap(send_quiet);
        send_quiet <= next_quiet(send_quiet);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) table_apply(s_tdata);
  end

  // Monitor: checks each accepted result word and stalls the output at random.
  always @(posedge clk) begin
    table_result_t want;
    int            stall;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall = recv_stall;
      if (m_tvalid && m_tready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          field_check("status", want.status, m_tdata[1:0]);
          field_check("hit_key", want.hit_key, m_tdata[17:2]);
          field_check("hit_value", want.hit_value, m_tdata[33:18]);
          field_check("hit_index", want.hit_index, m_tdata[40:34]);
          field_check("entry_count", want.entry_count, m_tdata[48:41]);
        end
        stall = pick_gap(recv_quiet);
        recv_quiet <= next_quiet(recv_quiet);
      end
      if (stall != 0) begin
        m_tready   <= 1'b0;
        recv_stall <= stall - 1;
      end else begin
        m_tready   <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  initial begin
    int         total;
    int         seg;
    int         len;
    int         n;
    int         roll;
    int         app_pct;
    int         del_pct;
    mix_t       mix;
    logic [2:0] op;
    logic [6:0] pos;

    // Directed part: empty table, extremes of every field, duplicates,
    // deletes that shift later entries, unknown commands and missing keys.
    queue_cmd(krt_pkg::CMD_SEARCH, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_READ,   16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 16'hFFFF, 16'hFFFF, 7'd127);
    queue_cmd(krt_pkg::CMD_APPEND, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_APPEND, 16'hFFFF, 16'hFFFF, 7'd127);
    queue_cmd(krt_pkg::CMD_APPEND, 16'h0000, 16'h1234, 7'd0);
    queue_cmd(krt_pkg::CMD_SEARCH, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_UPDATE, 16'h0000, 16'hABCD, 7'd0);
    queue_cmd(krt_pkg::CMD_SEARCH, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_READ,   16'h0000, 16'h0000, 7'd2);
    queue_cmd(krt_pkg::CMD_READ,   16'h0000, 16'h0000, 7'd3);
    queue_cmd(krt_pkg::CMD_READ,   16'hFFFF, 16'hFFFF, 7'd127);
    queue_cmd(krt_pkg::CMD_DELETE, 16'hFFFF, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_READ,   16'h0000, 16'h0000, 7'd1);
    queue_cmd(3'(krt_pkg::CMD_READ + 1), 16'hFFFF, 16'hFFFF, 7'd127);
    queue_cmd(3'(krt_pkg::CMD_READ + 2), 16'h5555, 16'hAAAA, 7'd42);
    queue_cmd(3'(CMD_CODE_MAX), 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_UPDATE, 16'h7777, 16'h1111, 7'd0);
    queue_cmd(krt_pkg::CMD_SEARCH, 16'h8000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_DELETE, 16'h0000, 16'h0000, 7'd0);
    queue_cmd(krt_pkg::CMD_APPEND, 16'h8000, 16'h8000, 7'd64);
    queue_cmd(krt_pkg::CMD_READ,   16'h0000, 16'h0000, 7'd0);

    // Random part in segments; the first one is mostly appends, to push the table toward full.
    total = 0;
    seg = 0;
    while (total < RANDOM_ITEMS) begin
      mix = (seg == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  begin app_pct = 80; del_pct = 5;  len = $urandom_range(150, 200); end
        MIX_DRAIN: begin app_pct = 10; del_pct = 45; len = $urandom_range(60, 160);  end
        default:   begin app_pct = 30; del_pct = 20; len = $urandom_range(60, 160);  end
      endcase
      for (n = 0; n < len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) op = 3'($urandom_range(krt_pkg::CMD_READ + 1, CMD_CODE_MAX));
        else if (roll < 2 + app_pct) op = krt_pkg::CMD_APPEND;
        else if (roll < 2 + app_pct + del_pct) op = krt_pkg::CMD_DELETE;
        else begin
          case (roll % 3)
            0:       op = krt_pkg::CMD_SEARCH;
            1:       op = krt_pkg::CMD_UPDATE;
            default: op = krt_pkg::CMD_READ;
          endcase
        end
        pos = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 31))
                                          : 7'($urandom_range(0, 127));
        queue_cmd(op, pick_key(), 16'($urandom_range(0, 16'hFFFF)), pos);
      end
      total += len;
      seg++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (command_backlog.size() != 0 || s_tvalid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 10) @(posedge clk);

    if (error_count == 0 && predicted_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
